// ===== rtl/sssd_pkg.sv =====
`default_nettype none

package sssd_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_ASCII = 3'd1,
		OP_RAW   = 3'd2,
		OP_CLEAR = 3'd3,
		OP_DOTS  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CHAR  = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BLINK_STATIC = 2'd0,
		BLINK_ALL    = 2'd1,
		BLINK_ONE    = 2'd2
	} blink_mode_t;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_NUM_DIGITS     = 3'd0;
	localparam logic [2:0] REG_BLINK_MODE     = 3'd1;
	localparam logic [2:0] REG_BLINK_PERIOD   = 3'd2;
	localparam logic [2:0] REG_BLINK_DIGIT    = 3'd3;
	localparam logic [2:0] REG_COMMON_CATHODE = 3'd4;

	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] DOT_BIT     = 8'h80;
	localparam logic [7:0] SEG_BLANK   = 8'h00;

	// one input word, tuser excluded
	typedef struct packed {
		logic       restart_scan;
		logic [2:0] dot_count;
		logic [7:0] data;
		logic [1:0] digit_index;
	} in_item_t;

	function automatic logic [7:0] digit_seg(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/seven_segment_scan_display_core.sv =====
`default_nettype none
// A word accepted on the slave side sits in the input register, and its result word is then
// loaded into the result register on the master side; a master stall holds it in the input register.
// Throughput: one word per cycle; the input register advances whenever the result
// register is empty or being drained, so ready falls only under master stall.
// Reset (arst_n low, asynchronous): digit store blank, scan index, blink counter and
// phase zero, num_digits 4, other configuration registers 0, both pipeline stages empty.
module seven_segment_scan_display_core #(
	parameter int DIGITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] digit_index, [9:2] data, [12:10] dot_count, [13] restart_scan, [15:14] zero
	input  wire logic [15:0] s_tdata,
	// [2:0] opcode
	input  wire logic [2:0]  s_tuser,
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] segments, [11:8] digit_enables, [13:12] status, [15:14] zero
	output logic [15:0]      m_tdata,
	// [0] drive_valid
	output logic             m_tuser,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import sssd_pkg::*;

	// scan never goes past four digits: the enable port is four wide
	localparam int ScanCap = (DIGITS < 4) ? DIGITS : 4;

	// configuration registers
	logic [2:0]  num_digits_q;
	logic [1:0]  blink_mode_q;
	logic [15:0] blink_period_q;
	logic [1:0]  blink_digit_q;
	logic        common_cathode_q;

	// display state
	logic [7:0]  store_q [DIGITS];
	logic [1:0]  scan_q;
	logic [15:0] blink_cnt_q;
	logic        phase_q;

	// input stage
	logic        valid_s1;
	in_item_t    item_s1;
	logic [2:0]  op_s1;

	// result register
	logic        m_tvalid_q;
	logic [7:0]  seg_q;
	logic [3:0]  en_q;
	logic        drive_q;
	logic [1:0]  status_q;

	logic        advance;
	logic        cfg_wr;

	// next-state and result logic
	logic [2:0]  used_n;
	logic [1:0]  sidx;
	logic [7:0]  rd_seg;
	logic        dark;
	logic [7:0]  seg_d;
	logic [3:0]  en_d;
	logic        drive_d;
	logic [1:0]  status_d;
	logic [7:0]  store_d [DIGITS];
	logic [1:0]  scan_d;
	logic [15:0] blink_cnt_d;
	logic        phase_d;
	logic [15:0] cnt_inc;
	logic        idx_bad;
	logic        is_num;
	logic [7:0]  ascii_seg;
	logic [3:0]  dot_end;
	logic        blinking;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		// used digit count, clamped to [1, ScanCap]
		used_n = num_digits_q;
		if (used_n == 3'd0)
			used_n = 3'd1;
		if (used_n > 3'(ScanCap))
			used_n = 3'(ScanCap);

		// a scan index left stale by a shrunken count restarts at digit zero
		sidx = ({1'b0, scan_q} >= used_n) ? 2'd0 : scan_q;

		rd_seg = SEG_BLANK;
		for (int i = 0; i < DIGITS; i++) begin
			if (3'(i) == {1'b0, sidx})
				rd_seg = store_q[i];
		end

		blinking = (blink_mode_q == BLINK_ALL) || (blink_mode_q == BLINK_ONE);
		dark = phase_q && ((blink_mode_q == BLINK_ALL) ||
			((blink_mode_q == BLINK_ONE) && (sidx == blink_digit_q)));

		idx_bad   = {1'b0, item_s1.digit_index} >= used_n;
		is_num    = (item_s1.data >= ASCII_ZERO) && (item_s1.data <= ASCII_NINE);
		ascii_seg = digit_seg(4'(item_s1.data - ASCII_ZERO));
		dot_end   = 4'(item_s1.digit_index) + 4'(item_s1.dot_count);
		cnt_inc   = blink_cnt_q + 16'd1;

		seg_d       = 8'h00;
		en_d        = 4'h0;
		drive_d     = 1'b0;
		status_d    = ST_OK;
		scan_d      = scan_q;
		blink_cnt_d = blink_cnt_q;
		phase_d     = phase_q;
		for (int i = 0; i < DIGITS; i++)
			store_d[i] = store_q[i];

		case (op_s1)
			OP_TICK: begin
				seg_d   = dark ? SEG_BLANK : rd_seg;
				en_d    = 4'b0001 << sidx;
				if (common_cathode_q) begin
					seg_d = ~seg_d;
					en_d  = ~en_d;
				end
				drive_d = 1'b1;
				scan_d  = ({1'b0, sidx} + 3'd1 >= used_n) ? 2'd0 : sidx + 2'd1;
				if (blinking) begin
					if (cnt_inc >= blink_period_q) begin
						blink_cnt_d = 16'd0;
						phase_d     = !phase_q;
					end else begin
						blink_cnt_d = cnt_inc;
					end
				end
			end
			OP_ASCII: begin
				if (idx_bad)
					status_d = ST_BAD_INDEX;
				else if (!is_num && item_s1.data != ASCII_SPACE)
					status_d = ST_BAD_CHAR;
				else begin
					for (int i = 0; i < DIGITS; i++) begin
						if (3'(i) == {1'b0, item_s1.digit_index})
							store_d[i] = is_num ? ascii_seg : SEG_BLANK;
					end
				end
				if (item_s1.restart_scan)
					scan_d = 2'd0;
			end
			OP_RAW: begin
				if (idx_bad)
					status_d = ST_BAD_INDEX;
				else begin
					for (int i = 0; i < DIGITS; i++) begin
						if (3'(i) == {1'b0, item_s1.digit_index})
							store_d[i] = item_s1.data;
					end
				end
				if (item_s1.restart_scan)
					scan_d = 2'd0;
			end
			OP_CLEAR: begin
				for (int i = 0; i < DIGITS; i++)
					store_d[i] = SEG_BLANK;
				if (item_s1.restart_scan)
					scan_d = 2'd0;
			end
			OP_DOTS: begin
				if (idx_bad)
					status_d = ST_BAD_INDEX;
				else begin
					// dot range clipped at the used count
					for (int i = 0; i < DIGITS; i++) begin
						if (4'(i) >= 4'(item_s1.digit_index) && 4'(i) < dot_end &&
							3'(i) < used_n)
							store_d[i] = store_q[i] | DOT_BIT;
					end
				end
				if (item_s1.restart_scan)
					scan_d = 2'd0;
			end
			default: begin
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[13:0]);
			op_s1   <= s_tuser;
		end
	end

	// state and configuration; the user must write configuration only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++)
				store_q[i] <= SEG_BLANK;
			scan_q           <= 2'd0;
			blink_cnt_q      <= 16'd0;
			phase_q          <= 1'b0;
			num_digits_q     <= 3'd4;
			blink_mode_q     <= BLINK_STATIC;
			blink_period_q   <= 16'd0;
			blink_digit_q    <= 2'd0;
			common_cathode_q <= 1'b0;
		end else begin
			if (advance) begin
				for (int i = 0; i < DIGITS; i++)
					store_q[i] <= store_d[i];
				scan_q      <= scan_d;
				blink_cnt_q <= blink_cnt_d;
				phase_q     <= phase_d;
			end
			if (cfg_wr) begin
				case (cfg_index)
					REG_NUM_DIGITS: num_digits_q <= cfg_data[2:0];
					REG_BLINK_MODE: begin
						blink_mode_q <= cfg_data[1:0];
						blink_cnt_q  <= 16'd0;
						if (cfg_data[1:0] == BLINK_STATIC)
							phase_q <= 1'b0;
					end
					REG_BLINK_PERIOD: begin
						blink_period_q <= cfg_data;
						blink_cnt_q    <= 16'd0;
					end
					REG_BLINK_DIGIT:    blink_digit_q <= cfg_data[1:0];
					REG_COMMON_CATHODE: common_cathode_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seg_q    <= seg_d;
			en_q     <= en_d;
			drive_q  <= drive_d;
			status_q <= status_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, status_q, en_q, seg_q};
	assign m_tuser  = drive_q;

	// a word leaving the input stage lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid_q)
		else $error("result register not loaded after advance");

	// the blink counter stays below the period or is zero
	a_blink_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(blink_cnt_q < blink_period_q) || (blink_cnt_q == 16'd0))
		else $error("blink counter past period");

	// a drive word in active-high polarity selects exactly one digit
	a_drive_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && drive_q && !common_cathode_q) |-> $onehot(en_q))
		else $error("digit enable not one-hot");

	// a drive word never carries an error status
	a_drive_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && drive_q) |-> (status_q == ST_OK))
		else $error("error status on drive word");

	// non-drive words leave the display ports dark
	a_write_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !drive_q) |-> (seg_q == 8'h00 && en_q == 4'h0))
		else $error("write word carries display data");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
	import sssd_pkg::*;

	localparam int DIGITS          = 4;
	localparam int SCAN_CAP        = 4;          // scan never runs past four digits
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 10;         // two-stage pipe, with margin
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_BLOCKS   = 9;
	localparam int BLOCK_WORDS     = 150;

	// opcodes the block has no use for; they must come back as an all-zero word
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// one result word as the block presents it
	typedef struct packed {
		logic [7:0] seg;
		logic [3:0] en;
		logic       drive;
		logic [1:0] status;
	} drive_word_t;

	// directed script: either a register write or an input word, the latter
	// optionally with its result typed in by hand
	typedef struct {
		bit          is_reg;
		logic [2:0]  code;
		in_item_t    word;
		logic [15:0] reg_val;
		bit          typed;
		drive_word_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	seven_segment_scan_display_core #(
		.DIGITS(DIGITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Display model: digit patterns, scan position, blink state and the
	// register copies, all updated at the edge where a word or a write is
	// taken by the block.
	// ------------------------------------------------------------------
	logic [7:0]  glyphs [0:DIGITS-1];
	logic [1:0]  scan_pos;
	logic [15:0] blink_cnt;
	logic        blank_on;
	logic [2:0]  digits_reg;
	logic [1:0]  blink_sel;
	logic [15:0] blink_len;
	logic [1:0]  blink_pick;
	logic        cathode;

	drive_word_t pending_drive [$];    // results still owed by the block
	script_row_t script [$];

	int unsigned words_in;
	int unsigned directed_words;
	int unsigned results_seen;
	int unsigned reg_writes;
	int unsigned fail_count;
	int unsigned cycles;
	int unsigned send_gap_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_asked;
	int unsigned hold_served;
	int unsigned hold_left;

	function automatic logic [7:0] numeral(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'h3f;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5b;
			4'd3: p = 8'h4f;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6d;
			4'd6: p = 8'h7d;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7f;
			default: p = 8'h6f;
		endcase
		return p;
	endfunction

	// digits actually scanned: zero counts as one, anything past the cap is the cap
	function automatic int unsigned live_digits();
		int unsigned n;
		n = digits_reg;
		if (n < 1) n = 1;
		if (n > SCAN_CAP) n = SCAN_CAP;
		if (n > DIGITS) n = DIGITS;
		return n;
	endfunction

	task automatic reset_model();
		int k;
		for (k = 0; k < DIGITS; k++) glyphs[k] = SEG_BLANK;
		scan_pos   = '0;
		blink_cnt  = '0;
		blank_on   = 1'b0;
		digits_reg = 3'd4;
		blink_sel  = BLINK_STATIC;
		blink_len  = '0;
		blink_pick = '0;
		cathode    = 1'b0;
	endtask

	task automatic load_reg(input logic [2:0] idx, input logic [15:0] val);
		case (idx)
			REG_NUM_DIGITS: digits_reg = val[2:0];
			REG_BLINK_MODE: begin
				blink_sel = val[1:0];
				blink_cnt = '0;
				if (blink_sel == BLINK_STATIC) blank_on = 1'b0;
			end
			REG_BLINK_PERIOD: begin
				blink_len = val;
				blink_cnt = '0;
			end
			REG_BLINK_DIGIT:    blink_pick = val[1:0];
			REG_COMMON_CATHODE: cathode = val[0];
			default: ;
		endcase
	endtask

	function automatic drive_word_t predict_drive(input logic [2:0] op, input in_item_t w);
		drive_word_t r;
		int unsigned n;
		int unsigned k;
		logic dark;
		r = '0;
		n = live_digits();
		case (op)
			OP_TICK: begin
				// scan may be stale after the digit count shrank
				if (scan_pos >= n) scan_pos = '0;
				dark = blank_on && (blink_sel == BLINK_ALL ||
					(blink_sel == BLINK_ONE && scan_pos == blink_pick));
				r.seg   = dark ? SEG_BLANK : glyphs[scan_pos];
				r.en    = 4'b0001 << scan_pos;
				if (cathode) begin
					r.seg = ~r.seg;
					r.en  = ~r.en;
				end
				r.drive = 1'b1;
				if (int'(scan_pos) + 1 >= n) scan_pos = '0;
				else scan_pos = scan_pos + 2'd1;
				// blink mode three behaves as static: counter and phase hold
				if (blink_sel == BLINK_ALL || blink_sel == BLINK_ONE) begin
					blink_cnt = blink_cnt + 16'd1;
					if (blink_cnt >= blink_len) begin
						blink_cnt = '0;
						blank_on  = ~blank_on;
					end
				end
			end
			OP_ASCII: begin
				// index is checked ahead of the character
				if (w.digit_index >= n) r.status = ST_BAD_INDEX;
				else if (w.data == ASCII_SPACE) glyphs[w.digit_index] = SEG_BLANK;
				else if (w.data >= ASCII_ZERO && w.data <= ASCII_NINE)
					glyphs[w.digit_index] = numeral(4'(w.data - ASCII_ZERO));
				else r.status = ST_BAD_CHAR;
			end
			OP_RAW: begin
				if (w.digit_index >= n) r.status = ST_BAD_INDEX;
				else glyphs[w.digit_index] = w.data;
			end
			OP_CLEAR: begin
				for (k = 0; k < DIGITS; k++) glyphs[k] = SEG_BLANK;
			end
			OP_DOTS: begin
				if (w.digit_index >= n) r.status = ST_BAD_INDEX;
				else begin
					for (k = w.digit_index; k < w.digit_index + w.dot_count && k < n; k++)
						glyphs[k] = glyphs[k] | DOT_BIT;
				end
			end
			default: ;
		endcase
		// restart only follows the write opcodes, errors included
		if (op != OP_TICK && op <= OP_DOTS && w.restart_scan) scan_pos = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Script helpers
	// ------------------------------------------------------------------
	function automatic in_item_t pack_word(input logic [1:0] idx, input logic [7:0] data,
			input logic [2:0] cnt, input logic restart);
		in_item_t w;
		w.digit_index  = idx;
		w.data         = data;
		w.dot_count    = cnt;
		w.restart_scan = restart;
		return w;
	endfunction

	// non-drive result carrying only a status
	function automatic drive_word_t quiet(input status_t st);
		drive_word_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	task automatic add_word(input logic [2:0] op, input in_item_t w);
		script_row_t row;
		row.is_reg = 1'b0;
		row.code   = op;
		row.word   = w;
		row.reg_val = '0;
		row.typed  = 1'b0;
		row.want   = '0;
		script.push_back(row);
	endtask

	task automatic add_fixed(input logic [2:0] op, input in_item_t w, input drive_word_t want);
		script_row_t row;
		row.is_reg  = 1'b0;
		row.code    = op;
		row.word    = w;
		row.reg_val = '0;
		row.typed   = 1'b1;
		row.want    = want;
		script.push_back(row);
	endtask

	task automatic add_reg(input logic [2:0] idx, input logic [15:0] val);
		script_row_t row;
		row.is_reg  = 1'b1;
		row.code    = idx;
		row.word    = '0;
		row.reg_val = val;
		row.typed   = 1'b0;
		row.want    = '0;
		script.push_back(row);
	endtask

	task automatic note_fail(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("MISMATCH @%0d: %s", cycles, what);
	endtask

	// ------------------------------------------------------------------
	// Slave side: one word per call, with random gaps ahead of it. The
	// expectation is worked out at the edge where the word is taken.
	// ------------------------------------------------------------------
	task automatic send_word(input logic [2:0] op, input in_item_t w, input bit typed,
			input drive_word_t want);
		drive_word_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, w};
		do @(posedge clk); while (!s_tready);
		r = predict_drive(op, w);
		pending_drive.push_back(typed ? want : r);
		words_in++;
	endtask

	// drop valid and wait for every owed result; each word gives exactly one,
	// so an empty queue means the pipe is empty too
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_drive.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		load_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Master side: random stalls, plus a long hold-off on request so the
	// pipe fills and the slave side backs up.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_OFF_CYCLES;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result check: oldest expectation against each word taken
	always @(posedge clk) begin
		drive_word_t got;
		drive_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.seg    = m_tdata[7:0];
			got.en     = m_tdata[11:8];
			got.status = m_tdata[13:12];
			got.drive  = m_tuser;
			results_seen++;
			if (pending_drive.size() == 0) begin
				note_fail($sformatf("result word with nothing owed: seg %02h en %1h drv %0d st %0d",
					got.seg, got.en, got.drive, got.status));
			end else begin
				want = pending_drive.pop_front();
				if (got.seg != want.seg || got.en != want.en || got.drive != want.drive ||
						got.status != want.status)
					note_fail($sformatf({"word %0d: seg %02h/%02h en %1h/%1h drv %0d/%0d ",
						"st %0d/%0d (expected/actual)"}, results_seen,
						want.seg, got.seg, want.en, got.en, want.drive, got.drive,
						want.status, got.status));
			end
		end
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still owed", cycles,
			pending_drive.size());
		$display("seven_segment_scan_display_core test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int i;
		int blk;
		int j;
		int unsigned pick;
		logic [2:0] op;
		logic [7:0] data;
		logic [15:0] period;
		logic [2:0] ndig;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_NUM_DIGITS;
		cfg_data = '0;
		words_in = 0;
		results_seen = 0;
		reg_writes = 0;
		fail_count = 0;
		cycles = 0;
		hold_asked = 0;
		hold_served = 0;
		hold_left = 0;
		send_gap_pct = 14;
		recv_stall_pct = 70;
		reset_model();

		// directed script, starting from the reset settings (four digits, static)
		add_fixed(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0),
			'{seg: SEG_BLANK, en: 4'b0001, drive: 1'b1, status: ST_OK});
		add_fixed(OP_ASCII, pack_word(2'd0, ASCII_ZERO, 3'd0, 1'b0), quiet(ST_OK));
		add_fixed(OP_ASCII, pack_word(2'd3, ASCII_NINE, 3'd0, 1'b0), quiet(ST_OK));
		add_fixed(OP_ASCII, pack_word(2'd1, ASCII_SPACE, 3'd0, 1'b0), quiet(ST_OK));
		// characters just outside the numerals on either side
		add_fixed(OP_ASCII, pack_word(2'd2, ASCII_ZERO - 8'd1, 3'd0, 1'b0), quiet(ST_BAD_CHAR));
		add_fixed(OP_ASCII, pack_word(2'd2, ASCII_NINE + 8'd1, 3'd0, 1'b0), quiet(ST_BAD_CHAR));
		add_fixed(OP_RAW, pack_word(2'd2, 8'hff, 3'd0, 1'b0), quiet(ST_OK));
		// dot range running off the end, then an empty one
		add_fixed(OP_DOTS, pack_word(2'd1, 8'h00, 3'd7, 1'b0), quiet(ST_OK));
		add_fixed(OP_DOTS, pack_word(2'd0, 8'hff, 3'd0, 1'b0), quiet(ST_OK));
		add_word(OP_TICK, pack_word(2'd3, 8'hff, 3'd7, 1'b0));
		add_fixed(OP_SPARE_LO, pack_word(2'd3, 8'hff, 3'd7, 1'b1), quiet(ST_OK));
		add_fixed(OP_RAW, pack_word(2'd1, 8'h00, 3'd0, 1'b1), quiet(ST_OK));
		// restart is ignored on a tick
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b1));
		add_fixed(OP_CLEAR, pack_word(2'd0, 8'h00, 3'd0, 1'b1), quiet(ST_OK));
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		// two digits: index check wins over a bad character
		add_reg(REG_NUM_DIGITS, 16'd2);
		add_fixed(OP_ASCII, pack_word(2'd3, 8'h78, 3'd0, 1'b0), quiet(ST_BAD_INDEX));
		add_fixed(OP_RAW, pack_word(2'd2, 8'h5a, 3'd0, 1'b0), quiet(ST_BAD_INDEX));
		add_fixed(OP_DOTS, pack_word(2'd2, 8'h00, 3'd1, 1'b0), quiet(ST_BAD_INDEX));
		// zero digits counts as one; inverted drive; blink every tick
		add_reg(REG_NUM_DIGITS, 16'd0);
		add_reg(REG_COMMON_CATHODE, 16'd1);
		add_reg(REG_BLINK_MODE, BLINK_ALL);
		add_reg(REG_BLINK_PERIOD, 16'd0);
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		// seven digits clamps to four; mode three holds the phase
		add_reg(REG_NUM_DIGITS, 16'd7);
		add_reg(REG_BLINK_MODE, 16'd3);
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		// shrink under a scan sitting on digit three
		add_reg(REG_NUM_DIGITS, 16'd2);
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		add_reg(REG_BLINK_MODE, BLINK_ONE);
		add_reg(REG_BLINK_DIGIT, 16'd1);
		add_reg(REG_BLINK_PERIOD, 16'd1);
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));
		add_word(OP_TICK, pack_word(2'd0, 8'h00, 3'd0, 1'b0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < script.size(); i++) begin
			if (script[i].is_reg) begin
				settle();
				write_reg(script[i].code, script[i].reg_val);
			end else begin
				send_word(script[i].code, script[i].word, script[i].typed, script[i].want);
			end
		end
		directed_words = words_in;

		// random blocks, each under its own register setting
		for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk < 3) begin
				send_gap_pct = 14;
				recv_stall_pct = 70;
			end else if (blk < 6) begin
				send_gap_pct = 70;
				recv_stall_pct = 14;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			case (blk)
				0: begin ndig = 3'd0; period = 16'd0;     end
				1: begin ndig = 3'd7; period = 16'hffff;  end
				2: begin ndig = 3'd1; period = 16'd1;     end
				default: begin
					ndig = 3'($urandom_range(1, 4));
					period = 16'($urandom_range(0, 7));
				end
			endcase
			settle();
			write_reg(REG_NUM_DIGITS, {13'd0, ndig});
			write_reg(REG_BLINK_PERIOD, period);
			write_reg(REG_BLINK_MODE, 16'((blk + 1) % 4));
			write_reg(REG_BLINK_DIGIT, 16'($urandom_range(0, 3)));
			write_reg(REG_COMMON_CATHODE, 16'(blk % 2));

			for (j = 0; j < BLOCK_WORDS; j++) begin
				// long master hold-off while words keep coming
				if (blk == 1 && j == 40) hold_asked++;
				// and once, the sender waits for the display to catch up
				if (blk == 4 && j == 75) settle();
				pick = $urandom_range(0, 99);
				data = 8'($urandom_range(0, 255));
				if (pick < 45) op = OP_TICK;
				else if (pick < 65) begin
					op = OP_ASCII;
					// mostly legal characters, the rest any byte
					if ($urandom_range(0, 4) != 0) begin
						pick = $urandom_range(0, 10);
						data = (pick == 10) ? ASCII_SPACE : ASCII_ZERO + 8'(pick);
					end
				end
				else if (pick < 77) op = OP_RAW;
				else if (pick < 87) op = OP_DOTS;
				else if (pick < 91) op = OP_CLEAR;
				else if (pick < 95) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				else op = 3'($urandom_range(0, 7));
				send_word(op, pack_word(2'($urandom_range(0, 3)), data,
					3'($urandom_range(0, 7)), ($urandom_range(0, 9) == 0)),
					1'b0, '0);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_drive.size() != 0)
			note_fail($sformatf("%0d results never arrived", pending_drive.size()));
		$display("covered %0d words (%0d directed), %0d result words checked, %0d register writes",
			words_in, directed_words, results_seen, reg_writes);
		$display("digit counts zero, in range and past the cap, blink static/all/one/held, %s",
			$sformatf("both polarities, %0d mismatches", fail_count));
		if (fail_count == 0) begin
			$display("seven_segment_scan_display_core test passed");
		end else begin
			$display("seven_segment_scan_display_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
